### hw/rtl/c6502_pkg.sv
// Package with the transaction types and constants of the 6502 execute unit.
`default_nettype none
package c6502_pkg;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [7:0]  operand;
    logic [15:0] effective_address;
    logic [15:0] next_pc;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] new_pc;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  flags_out;
    logic [1:0]  extra_cycles;
    logic        last;
  } out_t;

  localparam logic [7:0]  FlC = 8'h01;
  localparam logic [7:0]  FlZ = 8'h02;
  localparam logic [7:0]  FlI = 8'h04;
  localparam logic [7:0]  FlD = 8'h08;
  localparam logic [7:0]  FlB = 8'h10;
  localparam logic [7:0]  FlU = 8'h20;
  localparam logic [7:0]  FlV = 8'h40;
  localparam logic [7:0]  FlN = 8'h80;
  localparam logic [7:0]  SpReset = 8'hFD;
  localparam logic [7:0]  PReset = 8'h24;
  localparam logic [7:0]  StackPage = 8'h01;

endpackage
`default_nettype wire

### hw/rtl/cpu_6502_execute_unit.sv
// Top level of the 6502 execute unit: decode, execute and write-back queue.
//
// One instruction enters per cycle while the input is not stalled; its architectural
// effect is computed in a single combinational pass from the accepted input
// transaction straight to the register file and the result queue. Most instructions
// give one result transaction; PHA and PHP give one write, JSR two and BRK three
// stack writes, one per cycle unless the output stalls, from a three-entry result
// queue. The input stalls only while that queue cannot take the next instruction.
`default_nettype none
module cpu_6502_execute_unit import c6502_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic [7:0] a_q, x_q, y_q, s_q, p_q;
  logic [7:0] a_d, x_d, y_d, s_d, p_d;

  // Result queue: up to three entries shown in order.
  out_t       res_q [3];
  logic [1:0] cnt_q, head_q;
  logic       take, pop;

  assign pop = out_valid_o && !out_stall_i;
  // Accept when the queue empties this cycle (or is empty).
  assign in_stall_o  = !((cnt_q == 2'd0) || (cnt_q == 2'd1 && pop));
  assign take = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = res_q[head_q];

  logic [7:0]  op, m, mod_r, pushp;
  logic [15:0] ea, np, pc, t16, disp;
  logic [8:0]  sum;
  logic [7:0]  addm;
  logic        br_ok, is_br, do_add, wr_mem;
  logic [7:0]  wr_dat;
  logic [1:0]  npush, extra;
  logic [7:0]  pd [3];

  function automatic logic t8(input logic [7:0] v);
    t8 = v[7];
  endfunction

  always_comb begin
    op = in_data_i.cmd;
    m  = in_data_i.operand;
    ea = in_data_i.effective_address;
    np = in_data_i.next_pc;
    a_d = a_q; x_d = x_q; y_d = y_q; s_d = s_q; p_d = p_q;
    pc = np; is_br = 1'b0; br_ok = 1'b0;
    wr_mem = 1'b0; wr_dat = 8'h00; npush = 2'd0;
    pd[0] = 8'h00; pd[1] = 8'h00; pd[2] = 8'h00;
    t16 = 16'h0000; mod_r = 8'h00;
    pushp = p_q | FlB | FlU;
    do_add = 1'b0;
    addm = (op[7:5] == 3'b111) ? ~m : m;
    sum = {1'b0, a_q} + {1'b0, addm} + {8'h00, p_q[0]};
    // Read-modify-write ops share one shift, rotate, increment and decrement unit; op[7:5] selects the kind.
    case (op[7:5])
      3'b000:  mod_r = {m[6:0], 1'b0};
      3'b001:  mod_r = {m[6:0], p_q[0]};
      3'b010:  mod_r = {1'b0, m[7:1]};
      3'b011:  mod_r = {p_q[0], m[7:1]};
      3'b111:  mod_r = m + 8'd1;
      default: mod_r = m - 8'd1;
    endcase
    case (op)
      8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71,
      8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1: begin
        do_add = 1'b1;
        a_d = sum[7:0];
        p_d[0] = sum[8];
        p_d[6] = (~(a_q[7] ^ addm[7])) & (a_q[7] ^ sum[7]);
      end
      8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: a_d = a_q & m;
      8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11: a_d = a_q | m;
      8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51: a_d = a_q ^ m;
      8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: a_d = m;
      8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: x_d = m;
      8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: y_d = m;
      8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1: begin
        p_d[0] = a_q >= m; p_d[1] = (a_q == m); p_d[7] = t8(a_q - m);
      end
      8'hE0, 8'hE4, 8'hEC: begin
        p_d[0] = x_q >= m; p_d[1] = (x_q == m); p_d[7] = t8(x_q - m);
      end
      8'hC0, 8'hC4, 8'hCC: begin
        p_d[0] = y_q >= m; p_d[1] = (y_q == m); p_d[7] = t8(y_q - m);
      end
      8'h24, 8'h2C: begin
        p_d[1] = (a_q & m) == 8'h00; p_d[6] = m[6]; p_d[7] = m[7];
      end
      8'h0A: begin a_d = {a_q[6:0], 1'b0}; p_d[0] = a_q[7]; end
      8'h2A: begin a_d = {a_q[6:0], p_q[0]}; p_d[0] = a_q[7]; end
      8'h4A: begin a_d = {1'b0, a_q[7:1]}; p_d[0] = a_q[0]; end
      8'h6A: begin a_d = {p_q[0], a_q[7:1]}; p_d[0] = a_q[0]; end
      8'h06, 8'h16, 8'h0E, 8'h1E, 8'h26, 8'h36, 8'h2E, 8'h3E: begin
        wr_mem = 1'b1; wr_dat = mod_r; p_d[0] = m[7];
        p_d[1] = mod_r == 8'h00; p_d[7] = mod_r[7];
      end
      8'h46, 8'h56, 8'h4E, 8'h5E, 8'h66, 8'h76, 8'h6E, 8'h7E: begin
        wr_mem = 1'b1; wr_dat = mod_r; p_d[0] = m[0];
        p_d[1] = mod_r == 8'h00; p_d[7] = mod_r[7];
      end
      8'hE6, 8'hF6, 8'hEE, 8'hFE, 8'hC6, 8'hD6, 8'hCE, 8'hDE: begin
        wr_mem = 1'b1; wr_dat = mod_r;
        p_d[1] = mod_r == 8'h00; p_d[7] = mod_r[7];
      end
      8'hE8: x_d = x_q + 8'd1;
      8'hCA: x_d = x_q - 8'd1;
      8'hC8: y_d = y_q + 8'd1;
      8'h88: y_d = y_q - 8'd1;
      8'h90: begin is_br = 1'b1; br_ok = !p_q[0]; end
      8'hB0: begin is_br = 1'b1; br_ok = p_q[0]; end
      8'hF0: begin is_br = 1'b1; br_ok = p_q[1]; end
      8'hD0: begin is_br = 1'b1; br_ok = !p_q[1]; end
      8'h30: begin is_br = 1'b1; br_ok = p_q[7]; end
      8'h10: begin is_br = 1'b1; br_ok = !p_q[7]; end
      8'h70: begin is_br = 1'b1; br_ok = p_q[6]; end
      8'h50: begin is_br = 1'b1; br_ok = !p_q[6]; end
      8'h18: p_d[0] = 1'b0;
      8'h38: p_d[0] = 1'b1;
      8'hD8: p_d[3] = 1'b0;
      8'hF8: p_d[3] = 1'b1;
      8'h58: p_d[2] = 1'b0;
      8'h78: p_d[2] = 1'b1;
      8'hB8: p_d[6] = 1'b0;
      8'h4C, 8'h6C: pc = ea;
      8'h20: begin
        t16 = np - 16'd1;
        npush = 2'd2; pd[0] = t16[15:8]; pd[1] = t16[7:0];
        s_d = s_q - 8'd2; pc = ea;
      end
      8'h00: begin
        t16 = np + 16'd1;
        npush = 2'd3; pd[0] = t16[15:8]; pd[1] = t16[7:0]; pd[2] = pushp;
        s_d = s_q - 8'd3; p_d[2] = 1'b1; pc = ea;
      end
      8'h60: begin s_d = s_q + 8'd2; pc = ea + 16'd1; end
      8'h40: begin s_d = s_q + 8'd3; p_d = (m | FlU) & ~FlB; pc = ea; end
      8'h48: begin npush = 2'd1; pd[0] = a_q; s_d = s_q - 8'd1; end
      8'h08: begin npush = 2'd1; pd[0] = pushp; s_d = s_q - 8'd1; end
      8'h68: begin s_d = s_q + 8'd1; a_d = m; end
      8'h28: begin s_d = s_q + 8'd1; p_d = (m | FlU) & ~FlB; end
      8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91: begin
        wr_mem = 1'b1; wr_dat = a_q;
      end
      8'h86, 8'h96, 8'h8E: begin wr_mem = 1'b1; wr_dat = x_q; end
      8'h84, 8'h94, 8'h8C: begin wr_mem = 1'b1; wr_dat = y_q; end
      8'hAA: x_d = a_q;
      8'hA8: y_d = a_q;
      8'hBA: x_d = s_q;
      8'h8A: a_d = x_q;
      8'h98: a_d = y_q;
      8'h9A: s_d = x_q;
      default: ;
    endcase
    // Shared N/Z update for loads, logic ops, adds and subtracts, accumulator shifts, PLA, X/Y steps and transfers.
    case (op)
      8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31,
      8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11,
      8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51,
      8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1,
      8'h0A, 8'h2A, 8'h4A, 8'h6A, 8'h68, 8'h8A, 8'h98: begin
        p_d[1] = a_d == 8'h00; p_d[7] = a_d[7];
      end
      8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE, 8'hE8, 8'hCA, 8'hAA, 8'hBA: begin
        p_d[1] = x_d == 8'h00; p_d[7] = x_d[7];
      end
      8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC, 8'hC8, 8'h88, 8'hA8: begin
        p_d[1] = y_d == 8'h00; p_d[7] = y_d[7];
      end
      default: begin
        if (do_add) begin
          p_d[1] = a_d == 8'h00; p_d[7] = a_d[7];
        end
      end
    endcase
    // Taken branch target and its page-cross penalty.
    disp = {{8{m[7]}}, m};
    extra = 2'd0;
    if (is_br && br_ok) begin
      pc = np + disp;
      extra = (pc[15:8] != np[15:8]) ? 2'd2 : 2'd1;
    end
  end

  // Build result entries and load the queue on each accepted transaction.
  out_t base;
  always_comb begin
    base = '0;
    base.new_pc = pc;
    base.acc_out = a_d;
    base.x_out = x_d;
    base.y_out = y_d;
    base.sp_out = s_d;
    base.flags_out = p_d;
    base.extra_cycles = extra;
  end

  out_t ent [3];
  logic [1:0] nres;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ent[k] = base;
      ent[k].write_enable = 1'b1;
      ent[k].write_address = {StackPage, s_q - 8'(k)};
      ent[k].write_data = pd[k];
      ent[k].last = (2'(k) == npush - 2'd1);
    end
    nres = npush;
    if (npush == 2'd0) begin
      nres = 2'd1;
      ent[0] = base;
      ent[0].last = 1'b1;
      if (wr_mem) begin
        ent[0].write_enable = 1'b1;
        ent[0].write_address = ea;
        ent[0].write_data = wr_dat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q[0] <= ent[0];
      res_q[1] <= ent[1];
      res_q[2] <= ent[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 8'h00; x_q <= 8'h00; y_q <= 8'h00;
      s_q <= SpReset; p_q <= PReset;
      cnt_q <= 2'd0; head_q <= 2'd0;
    end else begin
      if (take) begin
        a_q <= a_d; x_q <= x_d; y_q <= y_d; s_q <= s_d; p_q <= p_d;
        cnt_q <= nres; head_q <= 2'd0;
      end else if (pop) begin
        cnt_q <= cnt_q - 2'd1; head_q <= head_q + 2'd1;
      end
    end
  end

  // With three entries pending, as after a BRK, the head still points at the first entry.
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3 ||
    head_q == 2'd0) else $error("queue head moved with three entries pending");
  // The entry shown last is marked last.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cnt_q == 2'd1) |-> out_data_o.last)
    else $error("final result not marked last");
  // No new transaction while more than one result waits.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > 2'd1) |-> in_stall_o) else $error("input accepted over pending pushes");

endmodule
`default_nettype wire

### tb/sv/cpu_6502_execute_unit_tb.sv
// Testbench of the 6502 execute unit: random and directed instructions checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module cpu_6502_execute_unit_tb;
  import c6502_pkg::*;

  // Opcodes used by name in the directed part and the predictor.
  localparam logic [7:0] OpBrk = 8'h00, OpPhp = 8'h08, OpJsr = 8'h20, OpPlp = 8'h28;
  localparam logic [7:0] OpRti = 8'h40, OpPha = 8'h48, OpRts = 8'h60, OpPla = 8'h68;
  localparam logic [7:0] OpAdc = 8'h69, OpSbc = 8'hE9, OpLda = 8'hA9, OpLdx = 8'hA2;
  localparam logic [7:0] OpLdy = 8'hA0, OpSta = 8'h8D, OpStx = 8'h8E, OpSty = 8'h8C;
  localparam logic [7:0] OpInc = 8'hEE, OpDec = 8'hCE, OpRor = 8'h6E, OpAsl = 8'h0A;
  localparam logic [7:0] OpBne = 8'hD0, OpBeq = 8'hF0, OpCmp = 8'hC9, OpBit = 8'h2C;
  localparam logic [7:0] OpTxs = 8'h9A, OpTsx = 8'hBA, OpSec = 8'h38, OpClc = 8'h18;
  localparam logic [7:0] OpJmp = 8'h4C, OpIllegal = 8'h02;
  localparam int unsigned CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  cpu_6502_execute_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  // Predictor state.
  logic [7:0] reg_a = 8'h00, reg_x = 8'h00, reg_y = 8'h00;
  logic [7:0] reg_s = SpReset, reg_p = PReset;

  in_t  instr_queue[$];
  out_t expected_results[$];
  int   error_count = 0;
  int   cycle_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void put_flag(logic [7:0] f, logic v);
    reg_p = v ? (reg_p | f) : (reg_p & ~f);
  endfunction

  function automatic void set_nz(logic [7:0] v);
    put_flag(FlZ, v == 8'h00);
    put_flag(FlN, v[7]);
  endfunction

  function automatic void add_carry(logic [7:0] m);
    logic [8:0] t;
    t = {1'b0, reg_a} + {1'b0, m} + {8'h00, reg_p[0]};
    put_flag(FlC, t[8]);
    put_flag(FlV, ((~(reg_a ^ m)) & (reg_a ^ t[7:0]) & 8'h80) != 0);
    reg_a = t[7:0];
    set_nz(reg_a);
  endfunction

  function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
    put_flag(FlC, r >= m);
    set_nz(r - m);
  endfunction

  // Shift, rotate, increment or decrement; kind 0..5 = ASL ROL LSR ROR INC DEC.
  function automatic logic [7:0] modify(int kind, logic [7:0] v);
    logic [7:0] r;
    logic c;
    c = reg_p[0];
    case (kind)
      0: begin r = v << 1; put_flag(FlC, v[7]); end
      1: begin r = {v[6:0], c}; put_flag(FlC, v[7]); end
      2: begin r = v >> 1; put_flag(FlC, v[0]); end
      3: begin r = {c, v[7:1]}; put_flag(FlC, v[0]); end
      4: r = v + 8'd1;
      default: r = v - 8'd1;
    endcase
    set_nz(r);
    return r;
  endfunction

  // Executes one instruction and queues the results it gives.
  function automatic void execute_instruction(in_t it);
    logic [7:0] m, op;
    logic [15:0] ea, np, pc, t16, disp;
    logic [15:0] waddr[3];
    logic [7:0] wdata[3];
    int nw, br, n, mk;
    logic [1:0] extra;
    out_t r;
    op = it.cmd; m = it.operand; ea = it.effective_address; np = it.next_pc;
    pc = np; nw = 0; br = -1; extra = 2'd0; mk = -1;
    case (op)
      8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: add_carry(m);
      8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1: add_carry(~m);
      8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: begin
        reg_a &= m; set_nz(reg_a); end
      8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11: begin
        reg_a |= m; set_nz(reg_a); end
      8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51: begin
        reg_a ^= m; set_nz(reg_a); end
      8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: begin
        reg_a = m; set_nz(m); end
      8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: begin reg_x = m; set_nz(m); end
      8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: begin reg_y = m; set_nz(m); end
      8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1: compare_reg(reg_a, m);
      8'hE0, 8'hE4, 8'hEC: compare_reg(reg_x, m);
      8'hC0, 8'hC4, 8'hCC: compare_reg(reg_y, m);
      8'h24, 8'h2C: begin
        put_flag(FlZ, (reg_a & m) == 0); put_flag(FlV, m[6]); put_flag(FlN, m[7]);
      end
      8'h0A: reg_a = modify(0, reg_a);
      8'h2A: reg_a = modify(1, reg_a);
      8'h4A: reg_a = modify(2, reg_a);
      8'h6A: reg_a = modify(3, reg_a);
      8'h06, 8'h16, 8'h0E, 8'h1E: mk = 0;
      8'h26, 8'h36, 8'h2E, 8'h3E: mk = 1;
      8'h46, 8'h56, 8'h4E, 8'h5E: mk = 2;
      8'h66, 8'h76, 8'h6E, 8'h7E: mk = 3;
      8'hE6, 8'hF6, 8'hEE, 8'hFE: mk = 4;
      8'hC6, 8'hD6, 8'hCE, 8'hDE: mk = 5;
      8'hE8: begin reg_x += 8'd1; set_nz(reg_x); end
      8'hCA: begin reg_x -= 8'd1; set_nz(reg_x); end
      8'hC8: begin reg_y += 8'd1; set_nz(reg_y); end
      8'h88: begin reg_y -= 8'd1; set_nz(reg_y); end
      8'h90: br = !reg_p[0];
      8'hB0: br = reg_p[0];
      8'hF0: br = reg_p[1];
      8'hD0: br = !reg_p[1];
      8'h30: br = reg_p[7];
      8'h10: br = !reg_p[7];
      8'h70: br = reg_p[6];
      8'h50: br = !reg_p[6];
      8'h18: put_flag(FlC, 1'b0);
      8'h38: put_flag(FlC, 1'b1);
      8'hD8: put_flag(FlD, 1'b0);
      8'hF8: put_flag(FlD, 1'b1);
      8'h58: put_flag(FlI, 1'b0);
      8'h78: put_flag(FlI, 1'b1);
      8'hB8: put_flag(FlV, 1'b0);
      8'h4C, 8'h6C: pc = ea;
      OpJsr: begin
        t16 = np - 16'd1;
        waddr[0] = {StackPage, reg_s}; wdata[0] = t16[15:8]; reg_s -= 8'd1;
        waddr[1] = {StackPage, reg_s}; wdata[1] = t16[7:0]; reg_s -= 8'd1;
        nw = 2; pc = ea;
      end
      OpBrk: begin
        t16 = np + 16'd1;
        waddr[0] = {StackPage, reg_s}; wdata[0] = t16[15:8]; reg_s -= 8'd1;
        waddr[1] = {StackPage, reg_s}; wdata[1] = t16[7:0]; reg_s -= 8'd1;
        waddr[2] = {StackPage, reg_s}; wdata[2] = reg_p | FlB | FlU; reg_s -= 8'd1;
        nw = 3; put_flag(FlI, 1'b1); pc = ea;
      end
      OpRts: begin reg_s += 8'd2; pc = ea + 16'd1; end
      OpRti: begin reg_s += 8'd3; reg_p = (m | FlU) & ~FlB; pc = ea; end
      OpPha: begin
        waddr[0] = {StackPage, reg_s}; wdata[0] = reg_a; reg_s -= 8'd1; nw = 1;
      end
      OpPhp: begin
        waddr[0] = {StackPage, reg_s}; wdata[0] = reg_p | FlB | FlU; reg_s -= 8'd1; nw = 1;
      end
      OpPla: begin reg_s += 8'd1; reg_a = m; set_nz(m); end
      OpPlp: begin reg_s += 8'd1; reg_p = (m | FlU) & ~FlB; end
      8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91: begin
        waddr[0] = ea; wdata[0] = reg_a; nw = 1; end
      8'h86, 8'h96, 8'h8E: begin waddr[0] = ea; wdata[0] = reg_x; nw = 1; end
      8'h84, 8'h94, 8'h8C: begin waddr[0] = ea; wdata[0] = reg_y; nw = 1; end
      8'hAA: begin reg_x = reg_a; set_nz(reg_x); end
      8'hA8: begin reg_y = reg_a; set_nz(reg_y); end
      OpTsx: begin reg_x = reg_s; set_nz(reg_x); end
      8'h8A: begin reg_a = reg_x; set_nz(reg_a); end
      8'h98: begin reg_a = reg_y; set_nz(reg_a); end
      OpTxs: reg_s = reg_x;
      default: ;
    endcase
    // Read-modify-write result goes back to the same address.
    if (mk >= 0) begin
      waddr[0] = ea; wdata[0] = modify(mk, m); nw = 1;
    end
    if (br == 1) begin
      disp = {{8{m[7]}}, m};
      pc = np + disp;
      extra = (pc[15:8] != np[15:8]) ? 2'd2 : 2'd1;
    end
    n = (nw > 0) ? nw : 1;
    for (int k = 0; k < n; k++) begin
      r.write_enable  = (k < nw);
      r.write_address = (k < nw) ? waddr[k] : 16'h0000;
      r.write_data    = (k < nw) ? wdata[k] : 8'h00;
      r.new_pc = pc; r.acc_out = reg_a; r.x_out = reg_x; r.y_out = reg_y;
      r.sp_out = reg_s; r.flags_out = reg_p; r.extra_cycles = extra;
      r.last = (k == n - 1);
      expected_results.push_back(r);
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_t make_instr(logic [7:0] op, logic [7:0] m, logic [15:0] ea,
                                     logic [15:0] np);
    in_t it;
    it.cmd = op; it.operand = m; it.effective_address = ea; it.next_pc = np;
    return it;
  endfunction

  // Stimulus: directed instructions, then random ones with a bias to real opcodes.
  initial begin
    logic [7:0] pick[] = '{OpAdc, OpSbc, OpLda, OpLdx, OpLdy, OpSta, OpStx, OpSty,
                           OpInc, OpDec, OpRor, OpAsl, OpBne, OpBeq, OpCmp, OpBit,
                           OpPha, OpPhp, OpPla, OpPlp, OpJsr, OpRts, OpBrk, OpRti,
                           OpSec, OpClc, OpTsx, OpJmp};
    logic [7:0] op;
    instr_queue.push_back(make_instr(OpLda, 8'h00, 16'h0000, 16'h0000));
    instr_queue.push_back(make_instr(OpAdc, 8'hFF, 16'hFFFF, 16'hFFFF));
    instr_queue.push_back(make_instr(OpLda, 8'h7F, 16'h1234, 16'h0202));
    instr_queue.push_back(make_instr(OpAdc, 8'h01, 16'h1234, 16'h0204));
    instr_queue.push_back(make_instr(OpSbc, 8'h80, 16'h1234, 16'h0206));
    instr_queue.push_back(make_instr(OpSta, 8'h00, 16'hFFFF, 16'h0209));
    instr_queue.push_back(make_instr(OpInc, 8'hFF, 16'h8000, 16'h020C));
    instr_queue.push_back(make_instr(OpDec, 8'h00, 16'h0000, 16'h020F));
    instr_queue.push_back(make_instr(OpRor, 8'h01, 16'h4321, 16'h0212));
    instr_queue.push_back(make_instr(OpBne, 8'h80, 16'h0000, 16'h0214));
    instr_queue.push_back(make_instr(OpBeq, 8'h7F, 16'h0000, 16'h02F0));
    instr_queue.push_back(make_instr(OpBne, 8'h02, 16'h0000, 16'h0300));
    instr_queue.push_back(make_instr(OpJsr, 8'h00, 16'hC000, 16'h0000));
    instr_queue.push_back(make_instr(OpBrk, 8'hAA, 16'hFFFE, 16'hFFFF));
    instr_queue.push_back(make_instr(OpPhp, 8'h00, 16'h0000, 16'h0400));
    instr_queue.push_back(make_instr(OpPlp, 8'hFF, 16'h0000, 16'h0401));
    instr_queue.push_back(make_instr(OpRti, 8'h10, 16'h5555, 16'h0402));
    instr_queue.push_back(make_instr(OpRts, 8'h00, 16'hFFFF, 16'h0403));
    instr_queue.push_back(make_instr(OpLdx, 8'h01, 16'h0000, 16'h0405));
    instr_queue.push_back(make_instr(OpTxs, 8'h00, 16'h0000, 16'h0406));
    instr_queue.push_back(make_instr(OpPha, 8'h00, 16'h0000, 16'h0407));
    instr_queue.push_back(make_instr(OpBrk, 8'h00, 16'h1000, 16'h0409));
    instr_queue.push_back(make_instr(OpIllegal, 8'h55, 16'hAAAA, 16'h040A));
    instr_queue.push_back(make_instr(OpBit, 8'hC0, 16'h2000, 16'h040D));
    for (int i = 0; i < 296; i++) begin
      if ($urandom_range(0, 3) == 0) op = 8'($urandom_range(0, 255));
      else op = pick[$urandom_range(0, pick.size() - 1)];
      instr_queue.push_back(make_instr(op, 8'($urandom_range(0, 255)),
                                       16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535))));
    end
  end

  // Reset and the end of the run.
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (instr_queue.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Driver: presents instructions at the falling edge and holds them while stalled.
  int   drive_gap = 0;
  logic in_accepted = 1'b0;
  always @(posedge clk_i) begin
    in_accepted <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) execute_instruction(in_data_i);
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_accepted)) begin
      if (drive_gap > 0) begin
        drive_gap <= drive_gap - 1;
        in_valid_i <= 1'b0;
      end else if (instr_queue.size() > 0 && !(in_accepted && $urandom_range(0, 2) == 0)) begin
        in_data_i <= instr_queue.pop_front();
        in_valid_i <= 1'b1;
        drive_gap <= gap_length();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, changed at the falling edge.
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left <= gap_length();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: compares every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        error_count = error_count + 1;
        if (error_count <= 10) $display("Unexpected result transaction %p", out_data_o);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o !== want) begin
          error_count = error_count + 1;
          if (error_count <= 10) $display("Mismatch: expected %p, actual %p", want, out_data_o);
        end
      end
    end
  end

endmodule
`default_nettype wire

### files.f
hw/rtl/c6502_pkg.sv
hw/rtl/cpu_6502_execute_unit.sv
tb/sv/cpu_6502_execute_unit_tb.sv
